[rtl/pcoa_pkg.sv]
// shared constants and helpers for the prior count offset adjust block
`default_nettype none
package pcoa_pkg;

  localparam int SIZE_W  = 48;
  localparam int SC_W    = 32;
  localparam int LOG_W   = 32;
  localparam int COUNT_W = 32;
  localparam int PRIOR_W = 24;
  localparam int V_W     = 49;

  localparam logic [63:0] LN2_Q64   = 64'hB17217F7D1CF79AB;
  localparam logic [39:0] LN2_Q40   = 40'(LN2_Q64 >> 24);
  localparam logic [33:0] LN2_Q34   = 34'(LN2_Q64 >> 30);
  localparam logic [30:0] LN2_Q31   = 31'(LN2_Q64 >> 33);
  localparam logic [30:0] LOG2E_Q30 = 31'h5C551D95;

  localparam logic [SIZE_W-1:0] SIZE_MAX48  = {SIZE_W{1'b1}};
  localparam logic [SC_W-1:0]   SCALED_MAX  = {SC_W{1'b1}};
  localparam logic [LOG_W-1:0]  LOG_NEG_SAT = 32'h8000_0000;

  // floor(2^32 / i) for the series terms
  function automatic logic [32:0] recip(input logic [3:0] i);
    logic [32:0] r;
    case (i)
      4'd1:    r = 33'h1_0000_0000;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/pcoa_exp.sv]
// iterative fixed-point exp: log library size in, library size out
`default_nettype none
module pcoa_exp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [31:0]            x,
  output logic                          done,
  output logic [pcoa_pkg::SIZE_W-1:0]   size
);
  import pcoa_pkg::*;

  typedef enum logic [2:0] {E_IDLE, E_T, E_Y, E_P, E_R, E_C, E_FIN} state_t;

  state_t             state;
  logic signed [31:0] xr;
  logic signed [7:0]  k;
  logic [30:0]        f31;
  logic [30:0]        y;
  logic [31:0]        term;
  logic [32:0]        m;
  logic [30:0]        vr;
  logic [30:0]        q0;
  logic [3:0]         i;

  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic [62:0]        u;
  logic [34:0]        qi;
  logic [34:0]        r;
  logic [31:0]        tn;
  logic [64:0]        shl;
  logic [6:0]         shr;
  logic [SIZE_W-1:0]  size_c;

  // one multiplier shared by the T, Y, P and R steps
  always_comb begin
    case (state)
      E_T: begin
        ma = {{2{xr[31]}}, xr};
        mb = {3'b000, LOG2E_Q30};
      end
      E_Y: begin
        ma = {3'b000, f31};
        mb = {3'b000, LN2_Q31};
      end
      E_P: begin
        ma = {2'b00, term};
        mb = {3'b000, y};
      end
      E_R: begin
        ma = {3'b000, vr};
        mb = {1'b0, recip(i)};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign u    = prod[62:0] + (63'd1 << 62);
  assign qi   = 35'(q0) * 35'(i);
  assign r    = {4'b0000, vr} - qi;
  assign tn   = (r >= 35'(i)) ? 32'(q0) + 32'd1 : 32'(q0);

  always_comb begin
    shl = 65'(m) << k[4:0];
    shr = 7'(8'sd15 - k);
    if (k >= 8'sd32) begin
      size_c = SIZE_MAX48;
    end else if (k >= 8'sd15) begin
      shl = 65'(m) << 5'(k - 8'sd15);
      size_c = (shl > 65'(SIZE_MAX48)) ? SIZE_MAX48 : shl[SIZE_W-1:0];
    end else begin
      size_c = SIZE_W'(m >> shr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        E_IDLE: begin
          if (start) begin
            xr    <= x;
            state <= E_T;
          end
        end
        E_T: begin
          k     <= $signed({1'b0, u[62:56]}) - 8'sd64;
          f31   <= u[55:25];
          state <= E_Y;
        end
        E_Y: begin
          y     <= prod[61:31];
          term  <= 32'h8000_0000;
          m     <= 33'h0_8000_0000;
          i     <= 4'd1;
          state <= E_P;
        end
        E_P: begin
          vr    <= prod[61:31];
          state <= E_R;
        end
        E_R: begin
          q0    <= prod[62:32];
          state <= E_C;
        end
        E_C: begin
          term <= tn;
          m    <= m + 33'(tn);
          i    <= i + 4'd1;
          if (i == 4'd12) begin
            state <= E_FIN;
          end else begin
            state <= E_P;
          end
        end
        E_FIN: begin
          size  <= size_c;
          done  <= 1'b1;
          state <= E_IDLE;
        end
        default: state <= E_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pcoa_div.sv]
// scaled prior: prior * size * n over the size sum, restoring division
`default_nettype none
module pcoa_div #(
  parameter int N_W   = 7,
  parameter int SUM_W = 54
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [pcoa_pkg::PRIOR_W-1:0]   prior,
  input  logic [pcoa_pkg::SIZE_W-1:0]    size,
  input  logic [N_W-1:0]                 n,
  input  logic [SUM_W-1:0]               sum,
  output logic                           done,
  output logic [pcoa_pkg::SC_W-1:0]      q,
  output logic                           sat
);
  import pcoa_pkg::*;

  localparam int NUM_W = 72 + N_W;

  typedef enum logic [2:0] {D_IDLE, D_MUL, D_CHK, D_DIV, D_FIN} state_t;

  state_t             state;
  logic [PRIOR_W-1:0] pr;
  logic [SIZE_W-1:0]  sz;
  logic [N_W-1:0]     nr;
  logic [SUM_W-1:0]   sm;
  logic [2:0]         mstep;
  logic [71:0]        acc;
  logic [NUM_W-1:0]   num;
  logic [SUM_W-1:0]   rem;
  logic [31:0]        low;
  logic [4:0]         bitc;

  logic [23:0]        ma, mb;
  logic [47:0]        prod;
  logic [SUM_W:0]     trial;
  logic               qbit;

  always_comb begin
    case (mstep)
      3'd0: begin
        ma = pr;
        mb = sz[23:0];
      end
      3'd1: begin
        ma = pr;
        mb = sz[47:24];
      end
      3'd2: begin
        ma = acc[23:0];
        mb = 24'(nr);
      end
      3'd3: begin
        ma = acc[47:24];
        mb = 24'(nr);
      end
      3'd4: begin
        ma = acc[71:48];
        mb = 24'(nr);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod  = ma * mb;
  assign trial = {rem, low[31]};
  assign qbit  = (trial >= {1'b0, sm});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          if (start) begin
            pr    <= prior;
            sz    <= size;
            nr    <= n;
            sm    <= sum;
            mstep <= 3'd0;
            sat   <= 1'b0;
            state <= D_MUL;
          end
        end
        D_MUL: begin
          mstep <= mstep + 3'd1;
          case (mstep)
            3'd0: acc <= 72'(prod);
            3'd1: acc <= acc + (72'(prod) << 24);
            3'd2: num <= NUM_W'(prod);
            3'd3: num <= num + (NUM_W'(prod) << 24);
            default: begin
              num   <= num + (NUM_W'(prod) << 48);
              state <= D_CHK;
            end
          endcase
        end
        D_CHK: begin
          // quotient of 2^32 or more, or a zero sum, saturates at once
          if ((num >> 32) >= NUM_W'(sm)) begin
            q     <= SCALED_MAX;
            sat   <= 1'b1;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            rem   <= SUM_W'(num >> 32);
            low   <= num[31:0];
            bitc  <= 5'd31;
            state <= D_DIV;
          end
        end
        D_DIV: begin
          rem  <= qbit ? SUM_W'(trial - {1'b0, sm}) : SUM_W'(trial);
          low  <= {low[30:0], 1'b0};
          q    <= {q[30:0], qbit};
          bitc <= bitc - 5'd1;
          if (bitc == 5'd0) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (q == SCALED_MAX) begin
            sat <= 1'b1;
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/pcoa_log.sv]
// iterative natural log in Q6.26 by normalising and repeated squaring
`default_nettype none
module pcoa_log (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pcoa_pkg::V_W-1:0]      v,
  output logic                          done,
  output logic [pcoa_pkg::LOG_W-1:0]    lg,
  output logic                          sat
);
  import pcoa_pkg::*;

  typedef enum logic [2:0] {L_IDLE, L_NORM, L_SQ, L_F1, L_F2} state_t;

  state_t             state;
  logic [63:0]        nv;
  logic [5:0]         p;
  logic [2:0]         step;
  logic [31:0]        m;
  logic [29:0]        fr;
  logic [4:0]         b;
  logic [63:0]        t1;

  logic [5:0]         sa;
  logic               top_zero;
  logic [63:0]        nv_next;
  logic [5:0]         p_next;
  logic [33:0]        ma, mb;
  logic [67:0]        prod;
  logic [32:0]        sq;
  logic signed [7:0]  pm16;
  logic signed [48:0] lp;
  logic signed [48:0] lsum;

  // binary search for the leading one, halving the shift each step
  assign sa       = 6'd32 >> step;
  assign top_zero = (nv & ~({64{1'b1}} >> sa)) == 64'd0;
  assign nv_next  = top_zero ? nv << sa : nv;
  assign p_next   = top_zero ? p - sa : p;

  always_comb begin
    case (state)
      L_SQ: begin
        ma = {2'b00, m};
        mb = {2'b00, m};
      end
      L_F1: begin
        ma = {4'b0000, fr};
        mb = LN2_Q34;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod = ma * mb;
  assign sq   = prod[63:31];
  assign pm16 = $signed({2'b00, p}) - 8'sd16;
  assign lp   = pm16 * $signed({1'b0, LN2_Q40});
  assign lsum = lp + $signed(49'(t1 >> 24));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        L_IDLE: begin
          if (start) begin
            if (v == '0) begin
              lg   <= LOG_NEG_SAT;
              sat  <= 1'b1;
              done <= 1'b1;
            end else begin
              nv    <= 64'(v);
              p     <= 6'd63;
              step  <= 3'd0;
              sat   <= 1'b0;
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          nv   <= nv_next;
          p    <= p_next;
          step <= step + 3'd1;
          if (step == 3'd5) begin
            m     <= nv_next[63:32];
            fr    <= '0;
            b     <= 5'd29;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          if (sq[32]) begin
            fr[b] <= 1'b1;
            m     <= sq[32:1];
          end else begin
            m <= sq[31:0];
          end
          b <= b - 5'd1;
          if (b == 5'd0) begin
            state <= L_F1;
          end
        end
        L_F1: begin
          t1    <= prod[63:0];
          state <= L_F2;
        end
        L_F2: begin
          lg    <= lsum[45:14];
          done  <= 1'b1;
          state <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/prior_count_offset_adjust_core.sv]
// prior count offset adjust: one row of libraries in, adjusted counts and offsets out
// Input transactions carry one library each: count, log_offset (Q6.26), prior (Q8.16)
// and last_lib. Each input is passed through the exp unit, during which in_stall is
// high. A row closes on last_lib or when MAX_LIBS libraries are held; then one result
// per library is produced in library order. Each result goes through the scale division
// (5 multiply steps, a range check and 32 quotient bits) and then the log unit (6
// normalise steps, 30 squarings, 2 final steps), or skips both when shared prior mode
// reuses stored values. No input is taken until the row's last result goes.
// The output register holds a result, with out_valid high, for as long as out_stall is
// high; the sequencer waits on it. Writing cfg_wr_en sets shared_prior_mode and drops
// any stored shared row, which is rebuilt by the next row that closes in that mode.
// Synchronous reset empties the row, clears the mode and the shared valid flag, and
// drops any pending output; the library stores keep their contents and need no clearing.
`default_nettype none
module prior_count_offset_adjust_core #(
  parameter int MAX_LIBS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [pcoa_pkg::COUNT_W-1:0]     count,
  input  logic signed [31:0]               log_offset,
  input  logic [pcoa_pkg::PRIOR_W-1:0]     prior,
  input  logic                             last_lib,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pcoa_pkg::SIZE_W-1:0]      adjusted_count,
  output logic signed [31:0]               adjusted_log_offset,
  output logic                             last_of_row,
  output logic                             saturated
);
  import pcoa_pkg::*;

  localparam int IDX_W = (MAX_LIBS > 1) ? $clog2(MAX_LIBS) : 1;
  localparam int CNT_W = $clog2(MAX_LIBS + 1);
  localparam int SUM_W = SIZE_W + IDX_W;

  typedef enum logic [2:0] {
    T_IDLE, T_EXP, T_RD, T_RDW, T_DIV, T_LOG, T_FORM, T_OUT
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  element_count;
  logic [SUM_W-1:0]  size_sum;
  logic              shared_valid;
  logic              mode;
  logic              last_r;
  logic [CNT_W-1:0]  row_n;
  logic [IDX_W-1:0]  emit_idx;
  logic              reuse_r;
  logic              store_r;
  logic [SC_W-1:0]   sc;
  logic [LOG_W-1:0]  lg_r;
  logic              sat_acc;

  logic [SIZE_W-1:0]  size_mem  [MAX_LIBS];
  logic [COUNT_W-1:0] count_mem [MAX_LIBS];
  logic [PRIOR_W-1:0] prior_mem [MAX_LIBS];
  logic [SC_W-1:0]    shsc_mem  [MAX_LIBS];
  logic [LOG_W-1:0]   shlg_mem  [MAX_LIBS];

  logic [SIZE_W-1:0]  size_q;
  logic [COUNT_W-1:0] count_q;
  logic [PRIOR_W-1:0] prior_q;
  logic [SC_W-1:0]    shsc_q;
  logic [LOG_W-1:0]   shlg_q;

  logic               accept;
  logic [IDX_W-1:0]   ld_idx;
  logic [CNT_W-1:0]   ec_inc;
  logic [CNT_W-1:0]   emit_next;
  logic               exp_done;
  logic [SIZE_W-1:0]  exp_size;
  logic               div_start;
  logic               div_done;
  logic [SC_W-1:0]    div_q;
  logic               div_sat;
  logic               log_start;
  logic               log_done;
  logic [LOG_W-1:0]   log_lg;
  logic               log_sat;
  logic [V_W-1:0]     log_v;
  logic [SIZE_W:0]    ac;

  assign in_stall  = (state != T_IDLE);
  assign accept    = in_valid && !in_stall;
  assign ld_idx    = element_count[IDX_W-1:0];
  assign ec_inc    = element_count + CNT_W'(1);
  assign emit_next = CNT_W'(emit_idx) + CNT_W'(1);
  assign div_start = (state == T_RDW) && !reuse_r;
  assign log_start = (state == T_DIV) && div_done;
  assign log_v     = V_W'(size_q) + (V_W'(div_q) << 1);
  assign ac        = ({17'd0, count_q} << 16) + (SIZE_W + 1)'(sc);

  pcoa_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .x     (log_offset),
    .done  (exp_done),
    .size  (exp_size)
  );

  pcoa_div #(
    .N_W   (CNT_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .prior (prior_q),
    .size  (size_q),
    .n     (row_n),
    .sum   (size_sum),
    .done  (div_done),
    .q     (div_q),
    .sat   (div_sat)
  );

  pcoa_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (log_start),
    .v     (log_v),
    .done  (log_done),
    .lg    (log_lg),
    .sat   (log_sat)
  );

  // library stores
  always_ff @(posedge clk) begin
    if (accept) begin
      count_mem[ld_idx] <= count;
      prior_mem[ld_idx] <= prior;
    end
    count_q <= count_mem[emit_idx];
    prior_q <= prior_mem[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (state == T_EXP && exp_done) begin
      size_mem[ld_idx] <= exp_size;
    end
    size_q <= size_mem[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (state == T_LOG && log_done && store_r) begin
      shsc_mem[emit_idx] <= sc;
      shlg_mem[emit_idx] <= log_lg;
    end
    shsc_q <= shsc_mem[emit_idx];
    shlg_q <= shlg_mem[emit_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      element_count <= '0;
      size_sum      <= '0;
      shared_valid  <= 1'b0;
      mode          <= 1'b0;
      out_valid     <= 1'b0;
      emit_idx      <= '0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            last_r <= last_lib;
            state  <= T_EXP;
          end
        end
        T_EXP: begin
          if (exp_done) begin
            size_sum      <= size_sum + SUM_W'(exp_size);
            element_count <= ec_inc;
            if (last_r || ec_inc == CNT_W'(MAX_LIBS)) begin
              row_n    <= ec_inc;
              emit_idx <= '0;
              reuse_r  <= mode && shared_valid;
              store_r  <= mode && !shared_valid;
              state    <= T_RD;
            end else begin
              state <= T_IDLE;
            end
          end
        end
        T_RD: state <= T_RDW;
        T_RDW: begin
          if (reuse_r) begin
            sc      <= shsc_q;
            lg_r    <= shlg_q;
            sat_acc <= (shsc_q == SCALED_MAX) || (shlg_q == LOG_NEG_SAT);
            state   <= T_FORM;
          end else begin
            sat_acc <= (size_q == SIZE_MAX48);
            state   <= T_DIV;
          end
        end
        T_DIV: begin
          if (div_done) begin
            sc      <= div_q;
            sat_acc <= sat_acc || div_sat;
            state   <= T_LOG;
          end
        end
        T_LOG: begin
          if (log_done) begin
            lg_r    <= log_lg;
            sat_acc <= sat_acc || log_sat;
            state   <= T_FORM;
          end
        end
        T_FORM: begin
          if (ac > (SIZE_W + 1)'(SIZE_MAX48)) begin
            adjusted_count <= SIZE_MAX48;
            saturated      <= 1'b1;
          end else begin
            adjusted_count <= ac[SIZE_W-1:0];
            saturated      <= sat_acc;
          end
          adjusted_log_offset <= $signed(lg_r);
          last_of_row         <= (emit_next == row_n);
          out_valid           <= 1'b1;
          state               <= T_OUT;
        end
        T_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_of_row) begin
              element_count <= '0;
              size_sum      <= '0;
              if (store_r) begin
                shared_valid <= 1'b1;
              end
              state <= T_IDLE;
            end else begin
              emit_idx <= emit_idx + IDX_W'(1);
              state    <= T_RD;
            end
          end
        end
        default: state <= T_IDLE;
      endcase
      if (cfg_wr_en) begin
        mode         <= cfg_wr_data;
        shared_valid <= 1'b0;
      end
    end
  end

  // no input transaction while a result is waiting
  a_no_accept_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    element_count <= CNT_W'(MAX_LIBS))
    else $error("element count beyond store depth");

  a_row_cleared: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_row && !cfg_wr_en) |=>
      (element_count == '0 && size_sum == '0 && !in_stall))
    else $error("row state not cleared after last result");

  a_emit_in_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (CNT_W'(emit_idx) < row_n))
    else $error("result index outside the row");

endmodule
`default_nettype wire

[sim/prior_count_offset_adjust_core_tb.sv]
// self-checking testbench for prior_count_offset_adjust_core: rows in, every result field checked
`timescale 1ns / 1ps
module prior_count_offset_adjust_core_tb;
  import pcoa_pkg::*;

  typedef struct {
    logic [SIZE_W-1:0] ac;
    logic [LOG_W-1:0]  lg;
    logic              last;
    logic              sat;
  } lib_result_t;

  typedef struct {
    logic [31:0]        c;
    logic [31:0]        lo;
    logic [PRIOR_W-1:0] pr;
    bit                 lst;
    bit                 known;
    logic [SIZE_W-1:0]  ac;
    logic [LOG_W-1:0]   lg;
    bit                 lg_known;
    bit                 sat;
  } lib_vec_t;

  logic clk, rst;
  logic cfg_wr_en, cfg_wr_data;
  logic in_valid, in_stall;
  logic [COUNT_W-1:0] count;
  logic signed [31:0] log_offset;
  logic [PRIOR_W-1:0] prior;
  logic last_lib;
  logic out_valid, out_stall;
  logic [SIZE_W-1:0] adjusted_count;
  logic signed [31:0] adjusted_log_offset;
  logic last_of_row, saturated;

  prior_count_offset_adjust_core u_top (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .count(count), .log_offset(log_offset),
    .prior(prior), .last_lib(last_lib), .out_valid(out_valid), .out_stall(out_stall),
    .adjusted_count(adjusted_count), .adjusted_log_offset(adjusted_log_offset),
    .last_of_row(last_of_row), .saturated(saturated)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // row state mirrored from the block
  logic [SIZE_W-1:0]  lib_size_q [64];
  logic [COUNT_W-1:0] lib_count_q [64];
  logic [PRIOR_W-1:0] lib_prior_q [64];
  logic [SC_W-1:0]    kept_scaled [64];
  logic [LOG_W-1:0]   kept_log [64];
  logic [63:0] size_total;
  int  libs_held, kept_len;
  bit  kept_valid, mode_q;

  lib_result_t want_q[$];
  int errors, items_sent, results_seen, rows_closed, sat_seen;
  int burst_left;

  lib_vec_t dir_tab[] = '{
    '{32'd0,        32'h0000_0000, 24'h000000, 1, 1, 48'h0, 32'h0, 1, 0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 24'hFFFFFF, 1, 1, SIZE_MAX48, 32'h0, 0, 1},
    // every size underflows: zero average
    '{32'd5,        32'h8000_0000, 24'h000001, 1, 1, 48'h1_0004_FFFF, 32'h0, 0, 1},
    // size overflow
    '{32'd0,        32'h7FFF_FFFF, 24'h000000, 1, 1, 48'h0, 32'h0, 0, 1},
    // second library has zero size and zero prior: log of zero
    '{32'd3,        32'h5000_0000, 24'h010000, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'd7,        32'h8000_0000, 24'h000000, 1, 1, 48'h7_0000, LOG_NEG_SAT, 1, 1},
    '{32'd100,      32'h3800_0000, 24'h008000, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'd2000,     32'h3412_3456, 24'h020000, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'h1234_5678, 32'h3A00_0000, 24'h000100, 1, 0, 48'h0, 32'h0, 0, 0},
    '{32'd1,        32'hF000_0000, 24'h010000, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'd2,        32'hFC00_0000, 24'hFFFFFF, 1, 0, 48'h0, 32'h0, 0, 0},
    '{32'hAAAA_5555, 32'h5555_AAAA, 24'h5A5A5A, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'h5555_AAAA, 32'hAAAA_5555, 24'hA5A5A5, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'h8000_0000, 32'h2C00_0001, 24'h800000, 1, 0, 48'h0, 32'h0, 0, 0},
    '{32'h0000_FFFF, 32'h5900_0000, 24'h7FFFFF, 1, 0, 48'h0, 32'h0, 0, 0},
    '{32'd42,       32'hFFFF_FFFF, 24'h000001, 0, 0, 48'h0, 32'h0, 0, 0},
    '{32'd43,       32'h0000_0001, 24'hFFFFFE, 1, 0, 48'h0, 32'h0, 0, 0}
  };

  function automatic logic [SIZE_W-1:0] lib_size(input logic [31:0] raw);
    longint x, t;
    logic [63:0] u, f31, y, term, m, r;
    int k;
    x = longint'($signed(raw));
    t = x * longint'({33'd0, LOG2E_Q30});
    u = t + (64'sd1 <<< 62);
    k = int'(u[63:56]) - 64;
    f31 = {33'd0, u[55:25]};
    y = (f31 * {33'd0, LN2_Q31}) >> 31;
    term = 64'd1 << 31;
    m = term;
    for (int i = 1; i <= 12; i++) begin
      term = ((term * y) >> 31) / i;
      m += term;
    end
    if (k >= 32) return SIZE_MAX48;
    if (k >= 15) begin
      r = m << (k - 15);
      return (r > {16'd0, SIZE_MAX48}) ? SIZE_MAX48 : r[SIZE_W-1:0];
    end
    if (15 - k >= 64) return '0;
    r = m >> (15 - k);
    return r[SIZE_W-1:0];
  endfunction

  function automatic logic [LOG_W-1:0] log_q26(input logic [63:0] v, inout bit sat);
    int p;
    logic [63:0] m, fr, s;
    longint l;
    if (v == 0) begin
      sat = 1;
      return LOG_NEG_SAT;
    end
    p = 63;
    while (!v[p]) p--;
    m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
    fr = '0;
    for (int b = 29; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        fr[b] = 1'b1;
        m >>= 1;
      end
    end
    l = longint'(p - 16) * longint'({24'd0, LN2_Q40})
      + longint'((fr * {30'd0, LN2_Q34}) >> 24);
    s = l >>> 14;
    return s[31:0];
  endfunction

  function automatic logic [SC_W-1:0] scaled_prior(input logic [PRIOR_W-1:0] pr,
      input logic [SIZE_W-1:0] sz, input int n, input logic [63:0] sum, inout bit sat);
    logic [127:0] q;
    if (sum == 0) begin
      sat = 1;
      return SCALED_MAX;
    end
    q = (128'(pr) * 128'(sz) * 128'(unsigned'(n))) / 128'(sum);
    if (q >= 128'(SCALED_MAX)) begin
      sat = 1;
      return SCALED_MAX;
    end
    return q[SC_W-1:0];
  endfunction

  task automatic take_library(input logic [31:0] c, input logic [31:0] lo,
      input logic [PRIOR_W-1:0] pr, input bit lst);
    int idx, n;
    bit reuse, keep, sat;
    logic [SC_W-1:0] sc;
    logic [LOG_W-1:0] lg;
    logic [63:0] ac;
    lib_result_t r;
    idx = (libs_held >= 64) ? 0 : libs_held;
    lib_count_q[idx] = c;
    lib_prior_q[idx] = pr;
    lib_size_q[idx] = lib_size(lo);
    size_total += lib_size_q[idx];
    libs_held = idx + 1;
    if (!lst && libs_held < 64) return;
    n = libs_held;
    reuse = mode_q && kept_valid;
    keep = mode_q && !kept_valid;
    for (int i = 0; i < n; i++) begin
      sat = 0;
      if (reuse) begin
        sc = kept_scaled[i];
        lg = kept_log[i];
        if (sc == SCALED_MAX || lg == LOG_NEG_SAT) sat = 1;
      end else begin
        if (lib_size_q[i] == SIZE_MAX48) sat = 1;
        sc = scaled_prior(lib_prior_q[i], lib_size_q[i], n, size_total, sat);
        lg = log_q26(64'(lib_size_q[i]) + 2 * 64'(sc), sat);
        if (keep) begin
          kept_scaled[i] = sc;
          kept_log[i] = lg;
        end
      end
      ac = (64'(lib_count_q[i]) << 16) + 64'(sc);
      if (ac > 64'(SIZE_MAX48)) begin
        ac = 64'(SIZE_MAX48);
        sat = 1;
      end
      r.ac = ac[SIZE_W-1:0];
      r.lg = lg;
      r.last = (i + 1 == n);
      r.sat = sat;
      want_q.push_back(r);
    end
    if (keep) begin
      kept_valid = 1;
      kept_len = n;
    end
    libs_held = 0;
    size_total = 0;
    rows_closed++;
  endtask

  // offer one library, in bursts with random gaps between them
  task automatic send_lib(input logic [31:0] c, input logic [31:0] lo,
      input logic [PRIOR_W-1:0] pr, input bit lst);
    bit acc;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    count <= c;
    log_offset <= lo;
    prior <= pr;
    last_lib <= lst;
    acc = 0;
    while (!acc) begin
      @(negedge clk);
      acc = !in_stall;
      @(posedge clk);
    end
    take_library(c, lo, pr, lst);
    items_sent++;
  endtask

  // sender stops until every expected result is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_mode(input bit v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mode_q = v;
    kept_valid = 0;
  endtask

  task automatic random_rows(input int n_items);
    int stop, len, cap;
    logic [31:0] c, lo;
    logic [PRIOR_W-1:0] pr;
    stop = items_sent + n_items;
    while (items_sent < stop) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      cap = (mode_q && kept_valid) ? kept_len : 64;
      if (len > cap) len = cap;
      for (int i = 0; i < len; i++) begin
        c = ($urandom_range(0, 2) == 0) ? $urandom() : $urandom_range(0, 5000);
        // mostly realistic library sizes, sometimes anything at all
        if ($urandom_range(0, 3) == 0) lo = $urandom();
        else lo = ($urandom_range(8, 17) << 26) | $urandom_range(0, 32'h3FF_FFFF);
        pr = ($urandom_range(0, 3) == 0) ? 24'($urandom()) : 24'($urandom_range(0, 32'h3FFFF));
        send_lib(c, lo, pr, i == len - 1);
      end
    end
  endtask

  // receiver stall pattern, with one long hold-off
  int style, style_left, hold_left;
  bit held;
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      style <= 0;
      style_left <= 0;
      hold_left <= 0;
      held <= 0;
    end else begin
      if (style_left == 0) begin
        style <= $urandom_range(0, 3);
        style_left <= $urandom_range(50, 300);
      end else begin
        style_left <= style_left - 1;
      end
      if (!held && items_sent >= 120) begin
        held <= 1;
        hold_left <= 3000;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= !out_stall;
        endcase
      end
    end
  end

  // check each result transaction against the oldest expectation
  always @(negedge clk) begin
    lib_result_t w;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (saturated) sat_seen++;
      if (want_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result ac=%h lg=%h", $time, adjusted_count,
                 adjusted_log_offset);
      end else begin
        w = want_q.pop_front();
        if (adjusted_count !== w.ac) begin
          errors++;
          $display("%0t: adjusted_count expected %h actual %h", $time, w.ac, adjusted_count);
        end
        if (adjusted_log_offset !== w.lg) begin
          errors++;
          $display("%0t: adjusted_log_offset expected %h actual %h", $time, w.lg,
                   adjusted_log_offset);
        end
        if (last_of_row !== w.last) begin
          errors++;
          $display("%0t: last_of_row expected %b actual %b", $time, w.last, last_of_row);
        end
        if (saturated !== w.sat) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, w.sat, saturated);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("prior_count_offset_adjust_core_tb: done, errors");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid <= 1'b0;
    count <= '0;
    log_offset <= '0;
    prior <= '0;
    last_lib <= 1'b0;
    size_total = 0;
    libs_held = 0;
    kept_len = 0;
    kept_valid = 0;
    mode_q = 0;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    rows_closed = 0;
    sat_seen = 0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_lib(dir_tab[i].c, dir_tab[i].lo, dir_tab[i].pr, dir_tab[i].lst);
      if (dir_tab[i].known) begin
        want_q[$].ac = dir_tab[i].ac;
        want_q[$].sat = dir_tab[i].sat;
        if (dir_tab[i].lg_known) want_q[$].lg = dir_tab[i].lg;
      end
    end

    set_mode(1'b0);
    random_rows(120);
    // a row with no closing flag fills the store
    for (int i = 0; i < 64; i++)
      send_lib($urandom(), ($urandom_range(10, 15) << 26) | $urandom_range(0, 32'h3FF_FFFF),
               24'($urandom()), 1'b0);

    set_mode(1'b1);
    for (int i = 0; i < 40; i++)
      send_lib($urandom_range(0, 9000), ($urandom_range(9, 16) << 26) | $urandom_range(0, 9999),
               24'($urandom()), i == 39);
    random_rows(100);

    set_mode(1'b0);
    random_rows(60);
    set_mode(1'b1);
    random_rows(60);

    drain();
    $display("covered %0d libraries in %0d rows, %0d results (%0d saturated)",
             items_sent, rows_closed, results_seen, sat_seen);
    $display("both prior modes, shared reuse rows, full-store row and long output hold-off");
    if (errors == 0) begin
      $display("prior_count_offset_adjust_core_tb: done, clean");
    end else begin
      $display("prior_count_offset_adjust_core_tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/pcoa_pkg.sv
rtl/pcoa_exp.sv
rtl/pcoa_div.sv
rtl/pcoa_log.sv
rtl/prior_count_offset_adjust_core.sv
sim/prior_count_offset_adjust_core_tb.sv
